// ===== src/u8d_pkg.sv =====
// Package with the shared types and constants of the UTF-8 stream decoder.
`default_nettype none

package u8d_pkg;

    // Field widths.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned PEND_W  = 2;

    // Byte classification constants.
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] END_BYTE  = 8'h00;

    // Byte order mark, dropped when it is the first point of a string.
    localparam logic [POINT_W-1:0] BOM_POINT = 21'h00FEFF;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [PEND_W-1:0]  pending;
        logic [POINT_W-1:0] partial;
        logic               at_start;
    } t_dec_state;

    localparam t_dec_state STATE_RESET = '{
        pending:  '0,
        partial:  '0,
        at_start: 1'b1
    };

    // Outcome of one decode step.
    typedef struct packed {
        logic               emit;
        logic [POINT_W-1:0] code_point;
    } t_step_res;

endpackage

`default_nettype wire

// ===== src/u8d_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the code point output.
`default_nettype none

interface u8d_byte_if;
    logic                       valid;
    logic                       ready;
    logic [u8d_pkg::BYTE_W-1:0] byte_value;
    logic                       string_start;

    modport source (output valid, output byte_value, output string_start, input ready);
    modport sink   (input valid, input byte_value, input string_start, output ready);
endinterface

interface u8d_point_if;
    logic                        valid;
    logic                        ready;
    logic [u8d_pkg::POINT_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

`default_nettype wire

// ===== src/u8d_step.sv =====
// Combinational decode of one byte against the current decoder state.
`default_nettype none

module u8d_step (
    input  wire u8d_pkg::t_dec_state          i_state,
    input  wire logic [u8d_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                         i_start,
    output u8d_pkg::t_dec_state               o_state,
    output u8d_pkg::t_step_res                o_res
);

    u8d_pkg::t_dec_state          s;
    u8d_pkg::t_dec_state          n;
    logic [u8d_pkg::PEND_W-1:0]   pend_dec;
    logic [u8d_pkg::POINT_W-1:0]  cont_bits;
    logic                         is_cont;
    logic                         done;
    logic                         drop;

    // A new string clears the state before the byte is looked at.
    assign s        = i_start ? u8d_pkg::STATE_RESET : i_state;
    assign pend_dec = s.pending - 2'd1;
    assign is_cont  = (i_byte & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG;

    // Place the six payload bits of a continuation byte at its slot.
    always_comb begin
        unique case (pend_dec)
            2'd0:    cont_bits = {15'b0, i_byte[5:0]};
            2'd1:    cont_bits = {9'b0, i_byte[5:0], 6'b0};
            2'd2:    cont_bits = {3'b0, i_byte[5:0], 12'b0};
            default: cont_bits = {i_byte[2:0], 18'b0};
        endcase
    end

    // Next state and whether a sequence completes with this byte.
    always_comb begin
        n    = s;
        done = 1'b0;
        priority if (i_byte == u8d_pkg::END_BYTE) begin
            n = u8d_pkg::STATE_RESET;
        end else if (s.pending != '0) begin
            n.pending = pend_dec;
            if (is_cont) begin
                n.partial = s.partial | cont_bits;
            end
            done = (pend_dec == '0);
        end else if (!i_byte[7]) begin
            n.partial = {13'b0, i_byte};
            done      = 1'b1;
        end else if (i_byte[6] && !i_byte[5]) begin
            n.partial = {10'b0, i_byte[4:0], 6'b0};
            n.pending = 2'd1;
        end else if (i_byte[6] && !i_byte[4]) begin
            n.partial = {5'b0, i_byte[3:0], 12'b0};
            n.pending = 2'd2;
        end else if (i_byte[6] && !i_byte[3]) begin
            n.partial = {i_byte[2:0], 18'b0};
            n.pending = 2'd3;
        end else begin
            // Stray continuation or overlong lead: skipped.
            n = s;
        end
        if (done) begin
            n.at_start = 1'b0;
        end
    end

    // The first completed point of a string is dropped when it is a BOM.
    assign drop = s.at_start && (n.partial == u8d_pkg::BOM_POINT);

    assign o_state          = n;
    assign o_res.emit       = done && !drop;
    assign o_res.code_point = n.partial;

endmodule

`default_nettype wire

// ===== src/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: input register, decode step, result register.
// The decoder takes one UTF-8 byte per request and returns a 21-bit code point request
// whenever a sequence completes; bytes that only start or continue a sequence, skipped
// bytes, the terminating zero byte and a leading byte order mark give no result. It
// accepts a byte in every clock cycle: a byte is held in an input register, decoded by
// a single shallow step that also updates the decoder state, and the point is written
// to a result register. The input stalls only while the result register holds a point
// that is not taken.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8d_byte_if.sink    i_byte,
    u8d_point_if.source o_point
);

    logic                          r_in_valid;
    logic [u8d_pkg::BYTE_W-1:0]    r_byte;
    logic                          r_start;
    u8d_pkg::t_dec_state           r_state;
    logic                          r_out_valid;
    logic [u8d_pkg::POINT_W-1:0]   r_code;

    u8d_pkg::t_dec_state           n_state;
    u8d_pkg::t_step_res            step_res;
    logic                          out_free;
    logic                          advance;

    // Handshake flow between the two register stages.
    assign out_free     = !r_out_valid || o_point.ready;
    assign advance      = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || advance;

    // Decode step.
    u8d_step u_step (
        .i_state (r_state),
        .i_byte  (r_byte),
        .i_start (r_start),
        .o_state (n_state),
        .o_res   (step_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_byte  <= i_byte.byte_value;
            r_start <= i_byte.string_start;
        end
    end

    // Decoder state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= u8d_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= advance && step_res.emit;
            end
        end
        if (advance && step_res.emit) begin
            r_code <= step_res.code_point;
        end
    end

    assign o_point.valid      = r_out_valid;
    assign o_point.code_point = r_code;

    // A zero byte leaves the decoder in its reset state.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_byte == u8d_pkg::END_BYTE)
        |=> (r_state.pending == '0) && r_state.at_start && (r_state.partial == '0))
        else $error("zero byte did not clear decoder state");

    // A point is only produced when no continuation bytes remain.
    a_emit_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_res.emit |-> (n_state.pending == '0) && !n_state.at_start)
        else $error("point emitted with a sequence still open");

    // The decoder state only moves when a byte is decoded.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("decoder state changed without a decoded byte");

    // A stalled result keeps the input register from being overwritten.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_byte) && $stable(r_start))
        else $error("pending byte lost during output stall");

endmodule

`default_nettype wire

// ===== test/utf8_stream_decoder_tb.sv =====
// Self-checking testbench for the UTF-8 stream decoder with a code point predictor.
`default_nettype none

module utf8_stream_decoder_tb;

    // Predicts the decoded code points from the accepted bytes and checks each result.
    class utf8_point_predictor;
        logic [u8d_pkg::PEND_W-1:0]  pending;
        logic [u8d_pkg::POINT_W-1:0] partial;
        logic                        at_start;
        logic [u8d_pkg::POINT_W-1:0] due_points[$];
        int unsigned                 errors;

        function new();
            restart_string();
            errors = 0;
        endfunction

        function void restart_string();
            pending  = '0;
            partial  = '0;
            at_start = 1'b1;
        endfunction

        // Called once per accepted byte request.
        function void note_byte(input logic [u8d_pkg::BYTE_W-1:0] b, input logic start);
            int  ones;
            logic drop;
            if (start) restart_string();
            if (b == u8d_pkg::END_BYTE) begin
                restart_string();
                return;
            end
            if (pending != 0) begin
                // A byte that is not a continuation still uses up its slot.
                pending = pending - 1'b1;
                if ((b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG)
                    partial = partial
                              | u8d_pkg::POINT_W'(32'(b[5:0]) << (6 * pending));
            end else if (!b[7]) begin
                partial = u8d_pkg::POINT_W'(b);
            end else if (b[6] && !(b[5] && b[4] && b[3])) begin
                ones    = !b[5] ? 1 : (!b[4] ? 2 : 3);
                partial = u8d_pkg::POINT_W'(32'(b & (8'h3F >> ones)) << (6 * ones));
                pending = u8d_pkg::PEND_W'(ones);
                return;
            end else begin
                // Stray continuation or a lead of five or more ones is skipped.
                return;
            end
            if (pending == 0) begin
                drop     = at_start && (partial == u8d_pkg::BOM_POINT);
                at_start = 1'b0;
                if (!drop) due_points = {due_points, partial};
            end
        endfunction

        // Called once per accepted code point request.
        function void check_point(input logic [u8d_pkg::POINT_W-1:0] got);
            logic [u8d_pkg::POINT_W-1:0] want;
            if (due_points.size() == 0) begin
                $display("%0t: unexpected code_point %06h, none expected", $time, got);
                errors++;
                return;
            end
            want = due_points.pop_front();
            if (got !== want) begin
                $display("%0t: code_point mismatch, expected %06h, actual %06h",
                         $time, want, got);
                errors++;
            end
        endfunction

        function void flag_leftover();
            foreach (due_points[i]) begin
                $display("%0t: code_point expected %06h, actual none", $time, due_points[i]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    u8d_byte_if  byte_ch ();
    u8d_point_if point_ch ();

    utf8_stream_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_point (point_ch)
    );

    utf8_point_predictor point_predictor = new();

    int          tx_mode;
    int          rx_mode;
    int          rx_hold_cycles;
    logic        start_flag;
    int unsigned bytes_sent;

    // Clock with a period of 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle length for one request: none, uniform 0..12, or mostly none.
    function automatic int draw_gap(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 12);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        endcase
    endfunction

    // Offers one byte after a random idle stretch and returns at its acceptance edge.
    task automatic send_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
        int   gap;
        logic start;
        gap        = draw_gap(tx_mode);
        start      = start_flag;
        start_flag = 1'b0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.byte_value   <= b;
        byte_ch.string_start <= start;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        point_predictor.note_byte(b, start);
        bytes_sent++;
    endtask

    // Continuation byte, now and then replaced by an arbitrary nonzero byte.
    function automatic logic [u8d_pkg::BYTE_W-1:0] cont_byte();
        if ($urandom_range(0, 24) == 0) return 8'($urandom_range(1, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // One character: mostly well-formed sequences of random content, some noise.
    task automatic send_char();
        int                         kind;
        int                         conts;
        logic [u8d_pkg::BYTE_W-1:0] lead;
        if ($urandom_range(0, 39) == 0) start_flag = 1'b1;
        kind = $urandom_range(0, 19);
        if (kind < 8) begin
            send_byte(8'($urandom_range(1, 127)));
            return;
        end
        if (kind >= 16) begin
            case (kind)
                16:      send_byte(8'h80 | 8'($urandom_range(0, 63)));
                17:      send_byte(8'hF8 | 8'($urandom_range(0, 7)));
                default: send_byte(8'($urandom_range(1, 255)));
            endcase
            return;
        end
        if (kind < 11) begin
            conts = 1;
            lead  = 8'hC0 | 8'($urandom_range(0, 31));
        end else if (kind < 14) begin
            conts = 2;
            lead  = 8'hE0 | 8'($urandom_range(0, 15));
        end else begin
            conts = 3;
            lead  = 8'hF0 | 8'($urandom_range(0, 7));
        end
        send_byte(lead);
        repeat (conts) send_byte(cont_byte());
    endtask

    // Sender stays idle until every expected code point has come back.
    task automatic wait_for_results();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (point_predictor.due_points.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random ready stalls, plus a long hold-off when requested.
    initial begin : receiver
        int gap;
        point_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                point_ch.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else begin
                gap = draw_gap(rx_mode);
                if (gap > 0) begin
                    point_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            point_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!point_ch.valid) @(posedge i_clk);
            point_predictor.check_point(point_ch.code_point);
        end
    end

    // Watchdog.
    initial begin : watchdog
        #(12 * 400000);
        $display("utf8_stream_decoder verification failed");
        $finish;
    end

    // Stimulus.
    initial begin : stimulus
        logic [8:0] directed[$];
        int         nchars;
        bit         held;
        bit         drained;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.byte_value   = '0;
        byte_ch.string_start = 1'b0;
        tx_mode              = 0;
        rx_mode              = 0;
        rx_hold_cycles       = 0;
        start_flag           = 1'b0;
        bytes_sent           = 0;
        held                 = 1'b0;
        drained              = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes, top bit is the string start flag: leading order mark
        // dropped, order mark later kept, ASCII, longest points, stray and
        // overlong bytes, a broken sequence, end of string and a restart
        // in the middle of a sequence.
        directed = {9'h1EF, 9'h0BB, 9'h0BF, 9'h041, 9'h0EF, 9'h0BB, 9'h0BF,
                    9'h07F, 9'h0C3, 9'h0A9, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
                    9'h080, 9'h0F8, 9'h0FF, 9'h0E2, 9'h041, 9'h0AC,
                    9'h0C3, 9'h000, 9'h0E2, 9'h1C0, 9'h080};
        foreach (directed[i]) begin
            start_flag = directed[i][8];
            send_byte(directed[i][7:0]);
        end

        // Random strings.
        while (bytes_sent < 780) begin
            if ($urandom_range(0, 2) == 0) begin
                tx_mode = $urandom_range(0, 2);
                rx_mode = $urandom_range(0, 2);
            end
            start_flag = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) begin
                send_byte(8'hEF);
                send_byte(8'hBB);
                send_byte(8'hBF);
            end
            nchars = $urandom_range(1, 12);
            repeat (nchars) send_char();
            if ($urandom_range(0, 3) != 0) send_byte(u8d_pkg::END_BYTE);

            // Long receiver stall while the sender keeps pushing ASCII.
            if (!held && bytes_sent > 300) begin
                held           = 1'b1;
                tx_mode        = 0;
                rx_hold_cycles = 150;
                repeat (30) send_byte(8'($urandom_range(1, 127)));
            end
            if ((!drained && bytes_sent > 500) || $urandom_range(0, 9) == 0) begin
                drained = 1'b1;
                wait_for_results();
            end
        end

        // Drain and let the pipeline settle.
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (point_predictor.due_points.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        point_predictor.flag_leftover();
        if (point_predictor.errors == 0) begin
            $display("utf8_stream_decoder verification clean");
        end else begin
            $display("utf8_stream_decoder verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
